// ===== src/packet_address_statistics_assert.svh =====
// Assertion macros shared by the checker.
`ifndef PACKET_ADDRESS_STATISTICS_ASSERT_SVH
`define PACKET_ADDRESS_STATISTICS_ASSERT_SVH

// Implication checked on every clock unless in reset.
`define PAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define PAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/pas_pkg.sv =====
package pas_pkg;

    localparam int NUM_TABLES        = 5;
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [15:0] ARP_KIND         = 16'h0806;
    localparam logic [15:0] FRAG_OFFSET_MASK = 16'h1fff;
    localparam logic [19:0] MICROS_MAX       = 20'd999999;
    localparam logic [19:0] MICROS_PER_SEC   = 20'd1000000;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    localparam logic [2:0] TBL_MAC_SRC = 3'd0;
    localparam logic [2:0] TBL_MAC_DST = 3'd1;
    localparam logic [2:0] TBL_IP_SRC  = 3'd2;
    localparam logic [2:0] TBL_IP_DST  = 3'd3;
    localparam logic [2:0] TBL_ARP     = 3'd4;

    typedef struct packed {
        logic        opcode;
        logic [31:0] stamp_seconds;
        logic [19:0] stamp_micros;
        logic [15:0] frame_length;
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
        logic [15:0] ether_kind;
        logic [15:0] fragment_field;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [2:0]  table_select;
        logic [5:0]  entry_index;
    } in_item_t;

    typedef struct packed {
        logic [31:0] packet_number;
        logic [31:0] elapsed_seconds;
        logic [19:0] elapsed_micros;
        logic [4:0]  dropped_mask;
        logic        entry_valid;
        logic [47:0] entry_key;
        logic [31:0] entry_count;
        logic [15:0] shortest_length;
        logic [15:0] longest_length;
        logic [47:0] length_total;
    } out_item_t;

    // Classified work handed from front to back.
    typedef struct packed {
        logic        query;
        logic [31:0] seconds;
        logic [19:0] micros;
        logic [15:0] frame_length;
        logic [4:0]  lookup_mask;    // tables that take a lookup
        logic        arp_second;     // ARP table takes a second key
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [2:0]  table_select;
        logic [5:0]  entry_index;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_SCAN,
        ST_WAIT,
        ST_QREAD,
        ST_QWAIT,
        ST_EMIT
    } back_state_t;

endpackage

// ===== src/pas_ram.sv =====
module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== src/pas_front.sv =====
module pas_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            ready,
    input  pas_pkg::in_item_t data,
    output logic            work_valid,
    input  logic            work_ready,
    output pas_pkg::work_t  work_data
);
    import pas_pkg::*;

    work_t             q_reg [QUEUE_DEPTH];
    logic              wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    work_t             cls;
    logic              push, pop;

    always_comb
    begin
        cls              = '0;
        cls.query        = (data.opcode == OP_QUERY);
        cls.seconds      = data.stamp_seconds;
        cls.micros       = (data.stamp_micros > MICROS_MAX) ? MICROS_MAX : data.stamp_micros;
        cls.frame_length = data.frame_length;
        cls.source_mac   = data.source_mac;
        cls.dest_mac     = data.dest_mac;
        cls.source_ip    = data.source_ip;
        cls.dest_ip      = data.dest_ip;
        cls.table_select = data.table_select;
        cls.entry_index  = data.entry_index;
        if (data.opcode == OP_UPDATE)
        begin
            cls.lookup_mask[TBL_MAC_SRC] = 1'b1;
            cls.lookup_mask[TBL_MAC_DST] = 1'b1;
            if (data.ether_kind == ARP_KIND)
            begin
                cls.lookup_mask[TBL_ARP] = 1'b1;
                cls.arp_second           = 1'b1;
            end
            else if ((data.fragment_field & FRAG_OFFSET_MASK) == 16'd0)
            begin
                cls.lookup_mask[TBL_IP_SRC] = 1'b1;
                cls.lookup_mask[TBL_IP_DST] = 1'b1;
            end
        end
    end

    assign ready      = (cnt_reg != 2'(QUEUE_DEPTH));
    assign work_valid = (cnt_reg != 2'd0);
    assign work_data  = q_reg[rd_ptr_reg];
    assign push       = valid && ready;
    assign pop        = work_valid && work_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end
endmodule

// ===== src/pas_back.sv =====
module pas_back #(
    parameter int TABLE_ENTRIES = pas_pkg::TABLE_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             work_valid,
    output logic             work_ready,
    input  pas_pkg::work_t   work_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pas_pkg::out_item_t out_data
);
    import pas_pkg::*;

    localparam int IW  = $clog2(TABLE_ENTRIES);
    localparam int FW  = $clog2(TABLE_ENTRIES + 1);
    localparam int AW  = $clog2(NUM_TABLES * TABLE_ENTRIES);
    localparam int DEP = NUM_TABLES * TABLE_ENTRIES;

    back_state_t state_reg, state_next;
    work_t       w_reg;
    logic [4:0]  todo_reg, todo_next;
    logic        arp2_reg, arp2_next;
    logic [2:0]  tbl_reg, tbl_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic [FW-1:0] fill_reg [NUM_TABLES];
    logic [4:0]  drop_reg;
    logic [31:0] pkts_reg;
    logic [31:0] first_s_reg;
    logic [19:0] first_us_reg;
    logic [15:0] min_reg, max_reg;
    logic [47:0] sum_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;

    logic [47:0] key_cur;
    logic        key_wr, cnt_wr;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [47:0] key_wdata, key_rdata;
    logic [31:0] cnt_wdata, cnt_rdata;
    logic [AW-1:0] base;

    function automatic logic [2:0] first_set(input logic [4:0] m);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 4; i >= 0; i--)
        begin
            if (m[i]) r = 3'(i);
        end
        return r;
    endfunction

    assign base = AW'(tbl_reg) * AW'(TABLE_ENTRIES);

    always_comb
    begin
        case (tbl_reg)
            TBL_MAC_SRC: key_cur = w_reg.source_mac;
            TBL_MAC_DST: key_cur = w_reg.dest_mac;
            TBL_IP_SRC:  key_cur = {16'd0, w_reg.source_ip};
            TBL_IP_DST:  key_cur = {16'd0, w_reg.dest_ip};
            TBL_ARP:     key_cur = arp2_reg ? w_reg.source_mac : w_reg.dest_mac;
            default:     key_cur = '0;
        endcase
    end

    pas_ram #(.WIDTH(48), .DEPTH(DEP)) u_keys (
        .clk(clk), .wr_en(key_wr), .wr_addr(wr_addr), .wr_data(key_wdata),
        .rd_addr(rd_addr), .rd_data(key_rdata)
    );
    pas_ram #(.WIDTH(32), .DEPTH(DEP)) u_counts (
        .clk(clk), .wr_en(cnt_wr), .wr_addr(wr_addr), .wr_data(cnt_wdata),
        .rd_addr(rd_addr), .rd_data(cnt_rdata)
    );

    // Scan: ST_SCAN issues read of idx, ST_WAIT compares it.
    logic        match;
    logic [FW-1:0] fill_cur;
    assign fill_cur = fill_reg[tbl_reg];
    assign match    = (key_rdata == key_cur);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (work_valid && !out_valid_reg)
                          state_next = work_data.query ? ST_QREAD : ST_PICK;
            ST_PICK:  state_next = (todo_reg == 5'd0) ? ST_EMIT : ST_SCAN;
            ST_SCAN:  state_next = (idx_reg >= fill_cur) ? ST_PICK : ST_WAIT;
            ST_WAIT:  state_next = match ? ST_PICK : ST_SCAN;
            ST_QREAD: state_next = ST_QWAIT;
            ST_QWAIT: state_next = ST_EMIT;
            ST_EMIT:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        work_ready = (state_reg == ST_IDLE) && !out_valid_reg;
        todo_next  = todo_reg;
        arp2_next  = arp2_reg;
        tbl_next   = tbl_reg;
        idx_next   = idx_reg;
        key_wr     = 1'b0;
        cnt_wr     = 1'b0;
        wr_addr    = base + AW'(idx_reg[IW-1:0]);
        key_wdata  = key_cur;
        cnt_wdata  = 32'd1;
        rd_addr    = base + AW'(idx_reg[IW-1:0]);
        case (state_reg)
            ST_IDLE:
            begin
                todo_next = work_data.lookup_mask;
                arp2_next = work_data.arp_second;
                tbl_next  = work_data.table_select;
                idx_next  = FW'(work_data.entry_index);
            end
            ST_PICK:
            begin
                tbl_next = first_set(todo_reg);
                idx_next = '0;
            end
            ST_SCAN:
            begin
                if (idx_reg >= fill_cur)
                begin
                    // new key: append unless full
                    if (fill_cur < FW'(TABLE_ENTRIES))
                    begin
                        key_wr = 1'b1;
                        cnt_wr = 1'b1;
                    end
                    if (tbl_reg == TBL_ARP && arp2_reg) arp2_next = 1'b0;
                    else todo_next[tbl_reg] = 1'b0;
                end
            end
            ST_WAIT:
            begin
                wr_addr = base + AW'(idx_reg[IW-1:0] - IW'(1));
                if (match)
                begin
                    cnt_wr    = (cnt_rdata != 32'hffff_ffff);
                    cnt_wdata = cnt_rdata + 32'd1;
                    if (tbl_reg == TBL_ARP && arp2_reg) arp2_next = 1'b0;
                    else todo_next[tbl_reg] = 1'b0;
                end
            end
            ST_QREAD:
            begin
                rd_addr = (tbl_reg < 3'(NUM_TABLES))
                        ? AW'(tbl_reg) * AW'(TABLE_ENTRIES) + AW'(idx_reg) : '0;
            end
            default: ;
        endcase
        if (state_reg == ST_SCAN && idx_reg < fill_cur) idx_next = idx_reg + FW'(1);
    end

    logic [31:0] pk_inc;
    logic        first;
    logic [47:0] sum_add;
    logic [48:0] sum_wide;
    always_comb
    begin
        first    = (pkts_reg == 32'd0);
        pk_inc   = (pkts_reg == 32'hffff_ffff) ? pkts_reg : pkts_reg + 32'd1;
        sum_wide = {1'b0, sum_reg} + 49'(w_reg.frame_length);
        sum_add  = sum_wide[48] ? 48'hffff_ffff_ffff : sum_wide[47:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            todo_reg      <= '0;
            arp2_reg      <= 1'b0;
            tbl_reg       <= '0;
            idx_reg       <= '0;
            drop_reg      <= '0;
            pkts_reg      <= '0;
            first_s_reg   <= '0;
            first_us_reg  <= '0;
            min_reg       <= 16'hffff;
            max_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TABLES; i++) fill_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            todo_reg  <= todo_next;
            arp2_reg  <= arp2_next;
            tbl_reg   <= tbl_next;
            idx_reg   <= idx_next;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (work_valid && !out_valid_reg) drop_reg <= '0;
                end
                ST_SCAN:
                begin
                    if (idx_reg >= fill_cur)
                    begin
                        if (fill_cur < FW'(TABLE_ENTRIES))
                            fill_reg[tbl_reg] <= fill_cur + FW'(1);
                        else
                            drop_reg[tbl_reg] <= 1'b1;
                    end
                end
                ST_EMIT: out_valid_reg <= 1'b1;
                default: ;
            endcase
            if (state_reg == ST_EMIT && !w_reg.query)
            begin
                pkts_reg <= pk_inc;
                if (first)
                begin
                    first_s_reg  <= w_reg.seconds;
                    first_us_reg <= w_reg.micros;
                end
                if (w_reg.frame_length <= min_reg) min_reg <= w_reg.frame_length;
                if (w_reg.frame_length >= max_reg) max_reg <= w_reg.frame_length;
                sum_reg <= sum_add;
            end
        end
    end

    // index compared at full width so a small table never aliases a large index
    logic qok;
    assign qok = (w_reg.table_select < 3'(NUM_TABLES))
              && (32'(w_reg.entry_index) < 32'(fill_reg[w_reg.table_select]));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && work_valid && !out_valid_reg) w_reg <= work_data;
        if (state_reg == ST_EMIT)
        begin
            out_reg <= '0;
            if (w_reg.query)
            begin
                out_reg.packet_number   <= pkts_reg;
                out_reg.entry_valid     <= qok;
                out_reg.entry_key       <= qok ? key_rdata : '0;
                out_reg.entry_count     <= qok ? cnt_rdata : '0;
                out_reg.shortest_length <= min_reg;
                out_reg.longest_length  <= max_reg;
                out_reg.length_total    <= sum_reg;
            end
            else
            begin
                out_reg.packet_number <= pk_inc;
                if (!first)
                begin
                    if (w_reg.micros >= first_us_reg)
                    begin
                        out_reg.elapsed_micros  <= w_reg.micros - first_us_reg;
                        out_reg.elapsed_seconds <= w_reg.seconds - first_s_reg;
                    end
                    else
                    begin
                        out_reg.elapsed_micros  <= MICROS_PER_SEC + w_reg.micros - first_us_reg;
                        out_reg.elapsed_seconds <= w_reg.seconds - first_s_reg - 32'd1;
                    end
                end
                out_reg.dropped_mask    <= drop_reg;
                out_reg.shortest_length <= (w_reg.frame_length <= min_reg)
                                         ? w_reg.frame_length : min_reg;
                out_reg.longest_length  <= (w_reg.frame_length >= max_reg)
                                         ? w_reg.frame_length : max_reg;
                out_reg.length_total    <= sum_add;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

// ===== src/packet_address_statistics.sv =====
// Channel   Handshake                 Payload
// input     in_valid / in_ready       in_data  (pas_pkg::in_item_t)
// output    out_valid / out_ready     out_data (pas_pkg::out_item_t)
//
// Back end works one transfer at a time behind a two-entry queue. An update makes two
// or four lookups, each a serial scan of the keys of one table in the table RAM, which
// has one read port and one write port; a query reads one entry. Reset clears control
// state, counters, totals and fill levels; table RAM needs no clearing. The back end
// idles while its result waits; the queue keeps accepting until it is full.
module packet_address_statistics #(
    parameter int TABLE_ENTRIES = pas_pkg::TABLE_ENTRIES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pas_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pas_pkg::out_item_t out_data
);
    import pas_pkg::*;

    logic  work_valid, work_ready;
    work_t work_data;

    // Front end: classify frame and queue it.
    pas_front u_front (
        .clk(clk), .rst_n(rst_n),
        .valid(in_valid), .ready(in_ready), .data(in_data),
        .work_valid(work_valid), .work_ready(work_ready), .work_data(work_data)
    );

    // Back end: table scans, totals, result register.
    pas_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .work_valid(work_valid), .work_ready(work_ready), .work_data(work_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );
endmodule

// ===== src/pas_checker.sv =====
`include "packet_address_statistics_assert.svh"
module pas_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input pas_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input pas_pkg::out_item_t out_data
);
    import pas_pkg::*;

    `PAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `PAS_ASSERT_IMPL(a_micros_range, clk, rst_n, out_valid, out_data.elapsed_micros <= MICROS_MAX)
    `PAS_ASSERT_IMPL(a_entry_zero, clk, rst_n, out_valid && !out_data.entry_valid, out_data.entry_count == 32'd0)
    `PAS_ASSERT_IMPL(a_len_order, clk, rst_n, out_valid && out_data.packet_number != 32'd0, out_data.shortest_length <= out_data.longest_length)
endmodule

bind packet_address_statistics pas_checker u_checker (.*);
